// File: hdl/mpf_pkg.sv
// Package for the mist overlay pixel fade core: geometry and table constants,
// request codes, payload structs and the front-to-back command format.
// No dependencies; mpf_front, mpf_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  // Texture and fade table geometry
  localparam int TEXTURE_DIM = 256;
  localparam int FADE_LEVELS = 33;
  localparam int MAX_LINE    = 4095;

  localparam int COORD_W    = 12;
  localparam int OFS_W      = $clog2(TEXTURE_DIM);
  localparam int TEX_AW     = 2 * OFS_W;
  localparam int TEX_DEPTH  = TEXTURE_DIM * TEXTURE_DIM;
  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 16;
  localparam int FADE_DEPTH = FADE_LEVELS * 256;
  localparam int FADE_AW    = $clog2(FADE_DEPTH);

  // Level is (a + b) >> 3, clamped to the last fade level
  localparam int LEVEL_SHIFT = 3;
  localparam int LEVEL_W     = PIX_W + 1 - LEVEL_SHIFT;
  localparam int LEVEL_MAX   = FADE_LEVELS - 1;

  // Lens divider is width / (2 * TEXTURE_DIM), at least one
  localparam int LENS_SHIFT = $clog2(2 * TEXTURE_DIM);
  localparam int LENS_W     = COORD_W - LENS_SHIFT;
  localparam int STEP_W     = $clog2(COORD_W);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Default queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 4;

  // Reset values of the geometry and the base offsets, and per-frame steps of the base offsets
  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = COORD_W'(640);
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = COORD_W'(480);
  localparam logic [OFS_W-1:0]   BASE_PX_RST  = OFS_W'(0);
  localparam logic [OFS_W-1:0]   BASE_PY_RST  = OFS_W'(0);
  localparam logic [OFS_W-1:0]   BASE_SX_RST  = OFS_W'(50);
  localparam logic [OFS_W-1:0]   BASE_SY_RST  = OFS_W'(128);
  localparam logic [OFS_W-1:0]   BASE_PX_STEP = OFS_W'(2);
  localparam logic [OFS_W-1:0]   BASE_PY_STEP = OFS_W'(1);
  localparam logic [OFS_W-1:0]   BASE_SX_STEP = OFS_W'(TEXTURE_DIM - 253);
  localparam logic [OFS_W-1:0]   BASE_SY_STEP = OFS_W'(3);

  typedef enum logic [1:0] {
    REQ_PIXEL   = 2'd0,
    REQ_TEX_WR  = 2'd1,
    REQ_FADE_WR = 2'd2
  } req_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] table_addr;
    logic [PIX_W-1:0]  table_data;
    logic [PIX_W-1:0]  src_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             line_end;
    logic             frame_end;
  } res_item_t;

  // Command from the front to the back. For pixels addr_a/addr_b are the
  // secondary and primary texture addresses and data is the source pixel;
  // for table writes addr_a is the table address and data the byte.
  typedef struct packed {
    req_e              kind;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [PIX_W-1:0]  data;
    logic              line_end;
    logic              frame_end;
  } cmd_t;

  typedef struct packed {
    logic               wr;
    reg_e               sel;
    logic [COORD_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } geom_t;

endpackage

`default_nettype wire

// File: hdl/mpf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/mpf_fifo.sv
// Small synchronous FIFO in flip-flops with occupancy count.
// No dependencies; used for the command queue and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module mpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           data_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IDX_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mpf_front.sv
// Front end of the mist overlay: geometry registers, lens divider remainders,
// running and base offsets, and classification of items into commands.
// Depends on mpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpf_front
  import mpf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_wr_t  cfg_i,
  output geom_t         geom_o,
  input  wire logic     push_i,
  input  wire in_item_t item_i,
  output logic          full_o,
  input  wire logic     cmd_full_i,
  output logic          cmd_push_o,
  output cmd_t          cmd_o
);

  logic [COORD_W-1:0] width_q, width_d, height_q, height_d;
  logic [COORD_W-1:0] eff_w, eff_h;
  logic [LENS_W-1:0]  div;

  logic [OFS_W-1:0] px_q, px_d, py_q, py_d, sx_q, sx_d, sy_q, sy_d;
  logic [OFS_W-1:0] bpx_q, bpx_d, bpy_q, bpy_d, bsx_q, bsx_d, bsy_q, bsy_d;
  logic [COORD_W-1:0] col_left_q, col_left_d, row_left_q, row_left_d;
  logic [LENS_W-1:0]  col_mod_q, col_mod_d, row_mod_q, row_mod_d;
  logic [LENS_W-1:0]  w_mod_q, w_mod_d, h_mod_q, h_mod_d;

  // Remainder unit: width mod div and height mod div, one bit per cycle
  logic               busy_q, busy_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [LENS_W-1:0]  rem_w_q, rem_w_d, rem_h_q, rem_h_d;
  logic [STEP_W-1:0]  bit_idx;
  logic [LENS_W:0]    sh_w, sh_h;

  logic accept, pix, col_step, row_step, lend, fend;
  req_e kind;

  assign geom_o.width  = width_q;
  assign geom_o.height = height_q;

  always_comb begin
    eff_w = width_q;
    if (width_q == '0) begin
      eff_w = COORD_W'(1);
    end else if (width_q > COORD_W'(MAX_LINE)) begin
      eff_w = COORD_W'(MAX_LINE);
    end
    eff_h = (height_q == '0) ? COORD_W'(1) : height_q;
    div   = (eff_w[COORD_W-1:LENS_SHIFT] == '0) ? LENS_W'(1)
                                                : eff_w[COORD_W-1:LENS_SHIFT];
  end

  assign bit_idx = STEP_W'(COORD_W - 1) - step_q;
  assign sh_w    = {rem_w_q, eff_w[bit_idx]};
  assign sh_h    = {rem_h_q, eff_h[bit_idx]};

  assign full_o = cmd_full_i | busy_q;
  assign accept = push_i & ~full_o;
  assign kind   = req_e'(item_i.req_type);

  always_comb begin
    pix        = 1'b0;
    cmd_push_o = 1'b0;
    unique case (kind) inside
      REQ_PIXEL: begin
        pix        = accept;
        cmd_push_o = accept;
      end
      REQ_TEX_WR, REQ_FADE_WR: begin
        cmd_push_o = accept;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

  assign col_step = (col_mod_q == '0);
  assign row_step = (row_mod_q == '0);
  assign lend     = (col_left_q == COORD_W'(1));
  assign fend     = lend & (row_left_q == COORD_W'(1));

  always_comb begin
    cmd_o.kind      = kind;
    cmd_o.line_end  = lend;
    cmd_o.frame_end = fend;
    if (kind == REQ_PIXEL) begin
      cmd_o.addr_a = {sy_q, sx_q};
      cmd_o.addr_b = {py_q, px_q};
      cmd_o.data   = item_i.src_pixel;
    end else begin
      cmd_o.addr_a = item_i.table_addr;
      cmd_o.addr_b = item_i.table_addr;
      cmd_o.data   = item_i.table_data;
    end
  end

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    px_d       = px_q;
    py_d       = py_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    bpx_d      = bpx_q;
    bpy_d      = bpy_q;
    bsx_d      = bsx_q;
    bsy_d      = bsy_q;
    col_left_d = col_left_q;
    row_left_d = row_left_q;
    col_mod_d  = col_mod_q;
    row_mod_d  = row_mod_q;
    w_mod_d    = w_mod_q;
    h_mod_d    = h_mod_q;
    busy_d     = busy_q;
    step_d     = step_q;
    rem_w_d    = rem_w_q;
    rem_h_d    = rem_h_q;

    if (cfg_i.wr) begin
      unique case (cfg_i.sel)
        REG_FRAME_WIDTH:  width_d  = cfg_i.data;
        REG_FRAME_HEIGHT: height_d = cfg_i.data;
      endcase
      busy_d  = 1'b1;
      step_d  = '0;
      rem_w_d = '0;
      rem_h_d = '0;
    end else if (busy_q) begin
      rem_w_d = (sh_w >= {1'b0, div}) ? LENS_W'(sh_w - {1'b0, div}) : sh_w[LENS_W-1:0];
      rem_h_d = (sh_h >= {1'b0, div}) ? LENS_W'(sh_h - {1'b0, div}) : sh_h[LENS_W-1:0];
      step_d  = step_q + 1'b1;
      if (step_q == STEP_W'(COORD_W - 1)) begin
        // Last bit done: restart the frame with the new geometry
        busy_d     = 1'b0;
        w_mod_d    = rem_w_d;
        h_mod_d    = rem_h_d;
        col_mod_d  = rem_w_d;
        row_mod_d  = rem_h_d;
        col_left_d = eff_w;
        row_left_d = eff_h;
        px_d       = bpx_q;
        py_d       = bpy_q;
        sx_d       = bsx_q;
        sy_d       = bsy_q;
      end
    end else if (pix) begin
      sy_d       = sy_q - OFS_W'(col_step);
      px_d       = px_q + OFS_W'(col_step);
      col_left_d = col_left_q - 1'b1;
      col_mod_d  = col_step ? div - 1'b1 : col_mod_q - 1'b1;
      if (lend) begin
        if (row_step) begin
          sy_d = sy_d + eff_w[OFS_W-1:0];
          px_d = px_d - eff_w[OFS_W-1:0];
          py_d = py_q + 1'b1;
          sx_d = sx_q - 1'b1;
        end
        col_left_d = eff_w;
        col_mod_d  = w_mod_q;
        row_left_d = row_left_q - 1'b1;
        row_mod_d  = row_step ? div - 1'b1 : row_mod_q - 1'b1;
        if (fend) begin
          bpx_d      = bpx_q + BASE_PX_STEP;
          bpy_d      = bpy_q + BASE_PY_STEP;
          bsx_d      = bsx_q + BASE_SX_STEP;
          bsy_d      = bsy_q + BASE_SY_STEP;
          px_d       = bpx_d;
          py_d       = bpy_d;
          sx_d       = bsx_d;
          sy_d       = bsy_d;
          row_left_d = eff_h;
          row_mod_d  = h_mod_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= FRAME_WIDTH_RST;
      height_q   <= FRAME_HEIGHT_RST;
      px_q       <= BASE_PX_RST;
      py_q       <= BASE_PY_RST;
      sx_q       <= BASE_SX_RST;
      sy_q       <= BASE_SY_RST;
      bpx_q      <= BASE_PX_RST;
      bpy_q      <= BASE_PY_RST;
      bsx_q      <= BASE_SX_RST;
      bsy_q      <= BASE_SY_RST;
      col_left_q <= FRAME_WIDTH_RST;
      row_left_q <= FRAME_HEIGHT_RST;
      col_mod_q  <= '0;
      row_mod_q  <= '0;
      w_mod_q    <= '0;
      h_mod_q    <= '0;
      busy_q     <= 1'b0;
      step_q     <= '0;
      rem_w_q    <= '0;
      rem_h_q    <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      px_q       <= px_d;
      py_q       <= py_d;
      sx_q       <= sx_d;
      sy_q       <= sy_d;
      bpx_q      <= bpx_d;
      bpy_q      <= bpy_d;
      bsx_q      <= bsx_d;
      bsy_q      <= bsy_d;
      col_left_q <= col_left_d;
      row_left_q <= row_left_d;
      col_mod_q  <= col_mod_d;
      row_mod_q  <= row_mod_d;
      w_mod_q    <= w_mod_d;
      h_mod_q    <= h_mod_d;
      busy_q     <= busy_d;
      step_q     <= step_d;
      rem_w_q    <= rem_w_d;
      rem_h_q    <= rem_h_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mpf_back.sv
// Back end of the mist overlay: mist texture lookups, fade level and fade
// table lookup, table writes, and the result queue.
// Depends on mpf_pkg, mpf_ram and mpf_fifo.
`timescale 1ns / 1ps
`default_nettype none

module mpf_back
  import mpf_pkg::*;
#(
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_empty_i,
  output logic       cmd_pop_o,
  output res_item_t  res_o,
  output logic       res_empty_o,
  input  wire logic  res_pop_i
);

  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  // Stage A: texture reads issued
  logic              a_valid_q;
  req_e              a_kind_q;
  logic [ADDR_W-1:0] a_addr_q;
  logic [PIX_W-1:0]  a_data_q;
  logic              a_lend_q, a_fend_q;
  // Stage B: fade read issued
  logic              b_valid_q;
  logic              b_lend_q, b_fend_q;

  logic [PIX_W-1:0]   tex_a, tex_b, fade_rd;
  logic [PIX_W:0]     mist_sum;
  logic [LEVEL_W-1:0] level;
  logic [FADE_AW-1:0] fade_raddr;
  logic               tex_we, tex_re, fade_we, fade_re, a_pix;
  logic [CNT_W-1:0]   res_cnt;
  logic [CNT_W+1:0]   in_flight;
  logic               res_full;
  res_item_t          res_in;

  assign a_pix     = a_valid_q & (a_kind_q == REQ_PIXEL);
  assign in_flight = (CNT_W + 2)'(res_cnt) + (CNT_W + 2)'(a_pix) + (CNT_W + 2)'(b_valid_q);
  assign cmd_pop_o = ~cmd_empty_i & (in_flight < (CNT_W + 2)'(RES_DEPTH));

  assign tex_we = cmd_pop_o & (cmd_i.kind == REQ_TEX_WR);
  assign tex_re = cmd_pop_o & (cmd_i.kind == REQ_PIXEL);

  // Two copies of the texture so both samples are read in the same cycle
  mpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TEX_DEPTH)
  ) u_tex_sec (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (cmd_i.addr_a[TEX_AW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (tex_re),
    .raddr_i (cmd_i.addr_a[TEX_AW-1:0]),
    .rdata_o (tex_a)
  );

  mpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TEX_DEPTH)
  ) u_tex_pri (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (cmd_i.addr_a[TEX_AW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (tex_re),
    .raddr_i (cmd_i.addr_b[TEX_AW-1:0]),
    .rdata_o (tex_b)
  );

  assign mist_sum = {1'b0, tex_a} + {1'b0, tex_b};

  always_comb begin
    level = mist_sum[PIX_W:LEVEL_SHIFT];
    if (level > LEVEL_W'(LEVEL_MAX)) begin
      level = LEVEL_W'(LEVEL_MAX);
    end
  end

  assign fade_raddr = FADE_AW'({level, a_data_q});
  assign fade_re    = a_pix;
  assign fade_we    = a_valid_q & (a_kind_q == REQ_FADE_WR) &
                      (a_addr_q < ADDR_W'(FADE_DEPTH));

  mpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FADE_DEPTH)
  ) u_fade (
    .clk_i   (clk_i),
    .we_i    (fade_we),
    .waddr_i (a_addr_q[FADE_AW-1:0]),
    .wdata_i (a_data_q),
    .re_i    (fade_re),
    .raddr_i (fade_raddr),
    .rdata_o (fade_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= cmd_pop_o;
      b_valid_q <= a_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    a_kind_q <= cmd_i.kind;
    a_addr_q <= cmd_i.addr_a;
    a_data_q <= cmd_i.data;
    a_lend_q <= cmd_i.line_end;
    a_fend_q <= cmd_i.frame_end;
    b_lend_q <= a_lend_q;
    b_fend_q <= a_fend_q;
  end

  assign res_in.out_pixel = fade_rd;
  assign res_in.line_end  = b_lend_q;
  assign res_in.frame_end = b_fend_q;

  mpf_fifo #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .data_i  (res_in),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .full_o  (res_full),
    .empty_o (res_empty_o),
    .count_o (res_cnt)
  );

  // Credit check above keeps the result queue from ever overflowing
  logic unused_full;
  assign unused_full = res_full;

endmodule

`default_nettype wire

// File: hdl/mist_overlay_pixel_fade_core.sv
// Mist overlay pixel fade core: top level with the configuration port.
// Depends on mpf_pkg, mpf_front, mpf_back and mpf_fifo.
//
// The core darkens a raster stream of palette pixels through a 33-level fade
// table, the level coming from two scrolling samples of a 256x256 mist
// texture. Items enter through a queue-style port (push/full) and results
// leave through another (empty/pop). Pixel items give exactly one result;
// texture and fade table writes, and the unused request code, give none, but
// they take effect in order with the pixels around them. The core sustains
// one item per clock while results are taken and no geometry write is in
// progress: the front end steps the texture offsets for one pixel each cycle,
// and the back end issues both texture reads in one cycle from two copies of
// the texture RAM and the fade read in the next. A small command queue
// between the front and the back end lets either side stall on its own, and
// the result queue keeps accepting while an earlier result waits to be taken.
// Writing frame_width (byte address 0) or frame_height (byte address 4)
// restarts the frame; after such a write full stays high while the core works
// out the remainders of the geometry by the lens divider, one bit per cycle.
// Texture and fade table contents are undefined after reset until written.
`timescale 1ns / 1ps
`default_nettype none

module mist_overlay_pixel_fade_core
  import mpf_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int RES_DEPTH = RES_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Item input
  input  wire logic               push,
  output logic                    full,
  input  wire in_item_t           in_item_i,
  // Result output
  output logic                    empty,
  input  wire logic               pop,
  output res_item_t               out_item_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_wr_t cfg;
  geom_t   geom;
  cmd_t    cmd_in, cmd_out;
  logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_cnt;
  reg_e    rd_sel;

  // The port never inserts wait states; a write lands in the access phase.
  assign pready   = 1'b1;
  assign cfg.wr   = psel & penable & pwrite & pready;
  assign cfg.sel  = reg_e'(paddr[2]);
  assign cfg.data = pwdata[COORD_W-1:0];

  assign rd_sel = reg_e'(paddr[2]);

  always_comb begin
    unique case (rd_sel)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(geom.width);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(geom.height);
    endcase
  end

  // Front end: classifies each transfer and tracks the texture offsets.
  mpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .geom_o     (geom),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Command queue decoupling the front end from the table lookups.
  mpf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .count_o (cmd_cnt)
  );

  // Occupancy is only needed by the queue's own full flag.
  logic unused_cnt;
  assign unused_cnt = ^cmd_cnt;

  // Back end: texture and fade lookups, table writes and result queue.
  mpf_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (out_item_o),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

endmodule

`default_nettype wire
